[rtl/msp_pkg.sv]
// msp_pkg: payload types, status codes, stage records and the exp2 table
// function of the masked scaled power unit
// no dependencies
package msp_pkg;

  // status codes of a result
  localparam logic [1:0] StComputed  = 2'd0;
  localparam logic [1:0] StPassed    = 2'd1;
  localparam logic [1:0] StSaturated = 2'd2;
  localparam logic [1:0] StZero      = 2'd3;

  // configuration register indexes
  localparam logic CfgScale    = 1'b0;
  localparam logic CfgExponent = 1'b1;

  localparam int LogFracBits = 20;
  localparam int MantBits    = 30;
  localparam logic [31:0] MaxOut = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [31:0] sample_value;
    logic        skip;
  } in_t;

  typedef struct packed {
    logic [31:0] powered_value;
    logic [1:0]  status;
  } out_t;

  // early result that rides along the pipe instead of the computed one
  typedef struct packed {
    logic        byp;
    logic [31:0] val;
    logic [1:0]  st;
  } side_t;

  // log2 stage record: mantissa Q1.30, exponent k-32, fraction so far
  typedef struct packed {
    logic [30:0] m;
    logic [6:0]  k;
    logic [19:0] frac;
    side_t       side;
  } log_t;

  // exp2 stage record: mantissa Q1.30, integer part, fraction bits
  typedef struct packed {
    logic [30:0] m;
    logic [10:0] n;
    logic [19:0] f;
    side_t       side;
  } exp_t;

  // integer square root, used only on constants
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    logic [63:0] r;
    res = '0;
    b   = 64'd1 << 62;
    r   = v;
    for (int j = 0; j < 32; j++) begin
      if (r >= res + b) begin
        r   = r - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // 2^(2^-i) in Q1.30 built by repeated square roots of 2.0
  function automatic logic [30:0] exp_tab(input int i);
    logic [63:0] t;
    t = 64'd1 << (MantBits + 1);
    for (int j = 1; j <= i; j++) begin
      t = isqrt64(t << MantBits);
    end
    return t[30:0];
  endfunction

endpackage

[rtl/masked_scaled_power.sv]
// masked_scaled_power: top level, front end, log2/exp2 pipes and output stage
// depends on msp_pkg, msp_log_stage, msp_exp_stage
//
// Element-wise power (scale_factor * sample_value) ^ exponent as
// 2^(exponent * log2(product)). One request is taken every cycle while the
// output is not stalled; the pipe is a chain of 45 register stages (product,
// normalise, 20 log2 squaring steps, exponent multiply, split, 20 exp2
// multiply steps, output) that all advance together, so a stalled output
// holds the whole pipe and nothing is lost or repeated.
// Masked entries, zero products and overflow take a side path that rides
// along the same stages. Configuration writes take effect at once and are
// meant for an empty pipe.
module masked_scaled_power import msp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [23:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_data_o
);

  logic        [23:0] scale_q;
  logic signed [19:0] exp_q;
  logic               en;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= 24'd65536;
      exp_q   <= 20'sd65536;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgScale:    scale_q <= cfg_data_i;
        CfgExponent: exp_q   <= cfg_data_i[19:0];
        default:     ;
      endcase
    end
  end

  // whole pipe moves when the output register is free
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // stage 0: product Q24.32
  logic        v0_q;
  logic [55:0] p_q;
  side_t       s0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q      <= 56'(scale_q) * 56'(in_data_i.sample_value);
      s0_q.byp <= in_data_i.skip;
      s0_q.val <= in_data_i.sample_value;
      s0_q.st  <= StPassed;
    end
  end

  // stage 1: normalise and handle a zero product
  logic [5:0]  lead;
  logic [85:0] shifted;
  log_t        n_d;
  logic        lv   [21];
  log_t        ld   [21];

  always_comb begin
    lead = '0;
    for (int j = 0; j < 56; j++) begin
      if (p_q[j]) lead = 6'(j);
    end
    shifted = (86'(p_q) << MantBits) >> lead;
    n_d.m    = shifted[30:0];
    n_d.k    = 7'(lead) - 7'd32;
    n_d.frac = '0;
    n_d.side = s0_q;
    if (!s0_q.byp && p_q == '0) begin
      n_d.side.byp = 1'b1;
      n_d.side.st  = StZero;
      if (exp_q > 0)       n_d.side.val = '0;
      else if (exp_q == 0) n_d.side.val = 32'd65536;
      else                 n_d.side.val = MaxOut;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lv[0] <= 1'b0;
    end else if (en) begin
      lv[0] <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ld[0] <= n_d;
    end
  end

  // log2 fraction, one bit per stage
  for (genvar g = 0; g < LogFracBits; g++) begin : g_log
    msp_log_stage u_log (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (lv[g]),
      .data_i  (ld[g]),
      .valid_o (lv[g+1]),
      .data_o  (ld[g+1])
    );
  end

  // exponent times log2, exact Q.36
  logic               vm_q;
  logic signed [46:0] el_q;
  side_t              sm_q;
  logic signed [26:0] lval;

  assign lval = $signed({ld[20].k, ld[20].frac});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
    end else if (en) begin
      vm_q <= lv[20];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      el_q <= 47'(exp_q) * 47'(lval);
      sm_q <= ld[20].side;
    end
  end

  // floor to Q.20, split into integer and fraction, catch overflow
  logic        [30:0] y;
  logic signed [10:0] nint;
  exp_t               x_d;
  logic               ev [21];
  exp_t               ed [21];

  always_comb begin
    y     = el_q[46:16];
    nint  = $signed(y[30:20]);
    x_d.m = 31'd1 << MantBits;
    x_d.n = y[30:20];
    x_d.f = y[19:0];
    x_d.side = sm_q;
    if (!sm_q.byp && nint >= 11'sd16) begin
      x_d.side.byp = 1'b1;
      x_d.side.val = MaxOut;
      x_d.side.st  = StSaturated;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev[0] <= 1'b0;
    end else if (en) begin
      ev[0] <= vm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ed[0] <= x_d;
    end
  end

  // exp2 of the fraction, one table multiply per stage
  for (genvar g = 0; g < LogFracBits; g++) begin : g_exp
    msp_exp_stage #(.IDX(g + 1)) u_exp (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (ev[g]),
      .data_i  (ed[g]),
      .valid_o (ev[g+1]),
      .data_o  (ed[g+1])
    );
  end

  // final scale by 2^n into Q16.16 and output register
  logic signed [10:0] nf;
  logic signed [11:0] sh;
  out_t               o_d;
  out_t               o_q;
  logic               ov_q;

  always_comb begin
    nf = $signed(ed[20].n);
    sh = 12'sd14 - 12'(nf);
    o_d.status = StComputed;
    if (nf == 11'sd15) begin
      o_d.powered_value = {ed[20].m, 1'b0};
    end else if (nf == 11'sd14) begin
      o_d.powered_value = {1'b0, ed[20].m};
    end else if (sh >= 12'sd32) begin
      o_d.powered_value = '0;
    end else begin
      o_d.powered_value = 32'(ed[20].m) >> sh[4:0];
    end
    if (ed[20].side.byp) begin
      o_d.powered_value = ed[20].side.val;
      o_d.status        = ed[20].side.st;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en) begin
      ov_q <= ev[20];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      o_q <= o_d;
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = o_q;

endmodule

[rtl/msp_log_stage.sv]
// msp_log_stage: one squaring step of the log2 fraction, one result bit
// depends on msp_pkg
module msp_log_stage import msp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  log_t data_i,
  output logic valid_o,
  output log_t data_o
);

  logic        valid_q;
  log_t        data_q;
  log_t        data_d;
  logic [61:0] sq;
  logic [31:0] s;

  // square the mantissa and renormalise into [1,2)
  always_comb begin
    sq     = 62'(data_i.m) * 62'(data_i.m);
    s      = sq[61:30];
    data_d = data_i;
    data_d.m    = s[31] ? s[31:1] : s[30:0];
    data_d.frac = {data_i.frac[18:0], s[31]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[rtl/msp_exp_stage.sv]
// msp_exp_stage: one conditional multiply by 2^(2^-IDX) of the exp2 build
// depends on msp_pkg
module msp_exp_stage import msp_pkg::*; #(
  parameter int IDX = 1
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  exp_t data_i,
  output logic valid_o,
  output exp_t data_o
);

  localparam logic [30:0] Tab = exp_tab(IDX);

  logic        valid_q;
  exp_t        data_q;
  exp_t        data_d;
  logic [61:0] pr;

  // multiply in the table entry when its fraction bit is set
  always_comb begin
    pr     = 62'(data_i.m) * 62'(Tab);
    data_d = data_i;
    if (data_i.f[LogFracBits - IDX]) begin
      data_d.m = pr[60:30];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// tb: self-checking bench for masked_scaled_power, with its own bit-exact power predictor
// depends on msp_pkg and the masked_scaled_power rtl
module tb;
  import msp_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [23:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  in_t         in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_t        out_data_o;

  masked_scaled_power dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  // bench copy of the registers and the exp2 root table
  logic [23:0] scale_reg;
  logic [19:0] power_reg;
  logic [63:0] root_tab [0:20];

  out_t        pending_powers [$];
  int          mismatches;
  int          results_seen;
  int          requests_sent;
  int          cycle_count;
  int          send_idle_pct;
  int          recv_stall_pct;

  localparam int CycleLimit = 400000;

  // clock
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // integer square root for the root table
  function automatic logic [63:0] int_root(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = '0;
    b   = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // expected result of one request under the current registers
  function automatic out_t predict_power(input in_t req);
    out_t        r;
    logic [63:0] prod;
    logic [63:0] m;
    logic [19:0] frac;
    longint      e;
    longint      lg;
    longint      y;
    longint      n;
    longint      f;
    int          k;
    if (req.skip) begin
      r.powered_value = req.sample_value;
      r.status        = StPassed;
      return r;
    end
    e    = longint'($signed(power_reg));
    prod = {40'd0, scale_reg} * {32'd0, req.sample_value};
    if (prod == 0) begin
      r.status        = StZero;
      r.powered_value = (e > 0) ? 32'd0 : ((e == 0) ? 32'd65536 : MaxOut);
      return r;
    end
    // log2 by squaring the normalised mantissa
    k = 63;
    while (!prod[k]) k--;
    m = (k > MantBits) ? (prod >> (k - MantBits)) : (prod << (MantBits - k));
    frac = '0;
    for (int i = 0; i < LogFracBits; i++) begin
      m    = (m * m) >> MantBits;
      frac = {frac[18:0], m >= (64'd1 << (MantBits + 1))};
      if (m >= (64'd1 << (MantBits + 1))) m = m >> 1;
    end
    lg = (longint'(k) - 32) * 64'sd1048576 + longint'({44'd0, frac});
    y  = (e * lg) >>> 16;
    n  = y >>> LogFracBits;
    f  = y - (n <<< LogFracBits);
    if (n >= 16) begin
      r.powered_value = MaxOut;
      r.status        = StSaturated;
      return r;
    end
    // exp2 of the fraction, then the integer shift
    m = 64'd1 << MantBits;
    for (int i = 1; i <= LogFracBits; i++)
      if (f[LogFracBits - i]) m = (m * root_tab[i]) >> MantBits;
    if (n >= 14) m = m << (n - 14);
    else if (14 - n >= 64) m = '0;
    else m = m >> (14 - n);
    if (m > {32'd0, MaxOut}) begin
      r.powered_value = MaxOut;
      r.status        = StSaturated;
    end else begin
      r.powered_value = m[31:0];
      r.status        = StComputed;
    end
    return r;
  endfunction

  // record the expectation of every accepted request
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      pending_powers.push_back(predict_power(in_data_i));
      requests_sent++;
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_powers.size() == 0) begin
        $display("%0t: unexpected result value %h status %0d", $time,
                 out_data_o.powered_value, out_data_o.status);
        mismatches++;
      end else begin
        want = pending_powers.pop_front();
        if (want.powered_value !== out_data_o.powered_value) begin
          $display("%0t: powered_value expected %h actual %h", $time,
                   want.powered_value, out_data_o.powered_value);
          mismatches++;
        end
        if (want.status !== out_data_o.status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   want.status, out_data_o.status);
          mismatches++;
        end
      end
    end
  end

  // receiver stalls
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // send one request, with random idle cycles ahead of it
  task automatic send_request(input logic [31:0] value, input logic skip);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i             <= 1'b1;
    in_data_i.sample_value <= value;
    in_data_i.skip         <= skip;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // wait until every expected result has come and the pipe is empty
  task automatic drain_pipe();
    in_valid_i <= 1'b0;
    while (pending_powers.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [23:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgScale) scale_reg = data;
    else power_reg = data[19:0];
    @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [23:0] scale, input logic [19:0] power);
    drain_pipe();
    write_reg(CfgScale, scale);
    write_reg(CfgExponent, {4'd0, power});
  endtask

  // extremes, masking and the zero product cases
  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_regs(24'h010000, 20'h10000);
    send_request(32'h0000_0000, 1'b0);
    send_request(32'h0000_0001, 1'b0);
    send_request(32'hFFFF_FFFF, 1'b0);
    send_request(32'h0001_0000, 1'b0);
    send_request(32'hFFFF_FFFF, 1'b1);
    send_request(32'h0000_0000, 1'b1);
    set_regs(24'h010000, 20'h00000);
    send_request(32'h0000_0000, 1'b0);
    send_request(32'h0005_0000, 1'b0);
    set_regs(24'h010000, 20'h80000);
    send_request(32'h0000_0000, 1'b0);
    send_request(32'h0000_0001, 1'b0);
    send_request(32'hFFFF_FFFF, 1'b0);
    set_regs(24'h010000, 20'h7FFFF);
    send_request(32'h0002_0000, 1'b0);
    send_request(32'h0001_0000, 1'b0);
    send_request(32'h0000_8000, 1'b0);
    set_regs(24'hFFFFFF, 20'h10000);
    send_request(32'hFFFF_FFFF, 1'b0);
    send_request(32'h0000_0001, 1'b0);
    set_regs(24'h000000, 20'h18000);
    send_request(32'h1234_5678, 1'b0);
    set_regs(24'h000001, 20'hF0000);
    send_request(32'h0000_0001, 1'b0);
    send_request(32'hFFFF_FFFF, 1'b0);
  endtask

  // random requests over a spread of magnitudes, with some zero and some masked
  task automatic random_burst(input int count, input bit pause_once);
    logic [31:0] value;
    int          pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 20) value = $urandom;
      else if (pick < 25) value = '0;
      else value = $urandom >> $urandom_range(31);
      if (pause_once && i == count / 2) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (pending_powers.size() != 0) @(posedge clk_i);
      end
      send_request(value, $urandom_range(99) < 20);
    end
  endtask

  task automatic test_random_phases();
    logic [23:0] scale;
    logic [19:0] power;
    int          idle_tab  [4] = '{0, 63, 0, 30};
    int          stall_tab [4] = '{0, 0, 63, 30};
    for (int p = 0; p < 12; p++) begin
      case (p % 6)
        0: begin
          scale = 24'($urandom_range(24'h008000, 24'h030000));
          power = 20'($urandom);
        end
        1: begin
          scale = 24'hFFFFFF;
          power = 20'($urandom_range(0, 20'h20000));
        end
        2: begin
          scale = 24'($urandom);
          power = 20'(20'h80000 | $urandom_range(20'h60000, 20'h7FFFF));
        end
        3: begin
          scale = 24'h010000;
          power = 20'($urandom_range(20'h04000, 20'h30000));
        end
        4: begin
          scale = 24'($urandom_range(1, 24'h000100));
          power = 20'h7FFFF;
        end
        default: begin
          scale = 24'($urandom);
          power = 20'($urandom_range(0, 20'hFFFFF));
        end
      endcase
      set_regs(scale, power);
      send_idle_pct  = idle_tab[p % 4];
      recv_stall_pct = stall_tab[p % 4];
      random_burst(100, p == 5);
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CfgScale;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    out_ready_i    = 1'b0;
    scale_reg      = 24'h010000;
    power_reg      = 20'h10000;
    mismatches     = 0;
    results_seen   = 0;
    requests_sent  = 0;
    cycle_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (int i = 0; i <= 20; i++)
      root_tab[i] = (i == 0) ? (64'd1 << (MantBits + 1)) : int_root(root_tab[i - 1] << MantBits);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_phases();
    drain_pipe();

    $display("requests %0d, results %0d, over masked, zero, saturating and computed powers",
             requests_sent, results_seen);
    $display("twelve register settings with sender gaps and receiver stalls in turn");
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
